[rtl/lcdws_pkg.sv]
// shared types, codes and constant tables for the character lcd write sequencer
// no dependencies; used by the controller, datapath, top level and checker
package lcdws_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_GOTO = 2'd2,
    REQ_INIT = 2'd3
  } req_type_t;

  // configuration register indexes
  localparam logic CFG_FOUR_BIT = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  localparam logic [15:0] HOLD_RESET = 16'd1000;

  // pin step positions within one byte
  localparam logic [2:0] STEP_RS     = 3'd0;
  localparam logic [2:0] STEP_E_HI   = 3'd1;
  localparam logic [2:0] STEP_HI_NIB = 3'd2;
  localparam logic [2:0] STEP_E_LO   = 3'd3;
  localparam logic [2:0] STEP_E_HI2  = 3'd4;
  localparam logic [2:0] STEP_LO_NIB = 3'd5;
  localparam logic [2:0] STEP_E_LO2  = 3'd6;

  // last byte index of the init sequence per bus mode
  localparam logic [1:0] INIT_LAST_FOUR  = 2'd3;
  localparam logic [1:0] INIT_LAST_EIGHT = 2'd2;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] NIB_HI_MASK   = 8'hF0;
  localparam logic [7:0] NIB_LO_MASK   = 8'h0F;

  // one request
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [3:0] column;
  } in_item_t;

  // one pin step
  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [7:0] bus_value;
    logic       last_step;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_HOLD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       emit;
    logic       four_bit;
    logic [2:0] step;
    logic [1:0] byte_idx;
    logic       last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic [1:0] req_type;
  } dp_status_t;

  // ddram base address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h10;
      default: base = 8'h50;
    endcase
    return base;
  endfunction

  // power-up command list
  function automatic logic [7:0] init_cmd(input logic four_bit, input logic [1:0] idx);
    logic [7:0] c;
    if (four_bit) begin
      unique case (idx)
        2'd0:    c = 8'h02;
        2'd1:    c = 8'h28;
        2'd2:    c = 8'h0C;
        default: c = 8'h01;
      endcase
    end else begin
      unique case (idx)
        2'd0:    c = 8'h38;
        2'd1:    c = 8'h0C;
        default: c = 8'h01;
      endcase
    end
    return c;
  endfunction

endpackage

[rtl/lcdws_ctrl.sv]
// sequencing controller: configuration registers, step and byte counters, hold timer
// depends on lcdws_pkg
module lcdws_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  output lcdws_pkg::ctrl_cmd_t   cmd,
  input  lcdws_pkg::dp_status_t  sts
);

  lcdws_pkg::state_t state_r, state_nxt;
  logic        four_bit_cfg_r;
  logic [15:0] hold_cfg_r;
  logic        mode_r, mode_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  byte_r, byte_nxt;
  logic [15:0] hold_cnt_r, hold_cnt_nxt;
  logic        done_r, done_nxt;
  logic        accept, emit, hold_over;
  logic        step_end, byte_end, is_init;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_cfg_r <= 1'b1;
      hold_cfg_r     <= lcdws_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdws_pkg::CFG_FOUR_BIT: four_bit_cfg_r <= cfg_wdata[0];
        lcdws_pkg::CFG_HOLD:     hold_cfg_r     <= cfg_wdata;
        default:                 hold_cfg_r     <= hold_cfg_r;
      endcase
    end
  end

  // position decode
  assign is_init   = (sts.req_type == lcdws_pkg::REQ_INIT);
  assign step_end  = mode_r ? (step_r == lcdws_pkg::STEP_E_LO2)
                            : (step_r == lcdws_pkg::STEP_E_LO);
  assign byte_end  = !is_init ||
                     (byte_r == (mode_r ? lcdws_pkg::INIT_LAST_FOUR
                                        : lcdws_pkg::INIT_LAST_EIGHT));
  assign hold_over = (hold_cnt_r <= 16'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcdws_pkg::ST_IDLE: if (in_valid) state_nxt = lcdws_pkg::ST_EMIT;
      lcdws_pkg::ST_EMIT: if (sts.out_free) state_nxt = lcdws_pkg::ST_HOLD;
      lcdws_pkg::ST_HOLD: begin
        if (hold_over) state_nxt = done_r ? lcdws_pkg::ST_IDLE : lcdws_pkg::ST_EMIT;
      end
      default: state_nxt = lcdws_pkg::ST_IDLE;
    endcase
  end

  // outputs and counter updates
  always_comb begin
    accept       = 1'b0;
    emit         = 1'b0;
    in_stall     = 1'b1;
    mode_nxt     = mode_r;
    step_nxt     = step_r;
    byte_nxt     = byte_r;
    hold_cnt_nxt = hold_cnt_r;
    done_nxt     = done_r;
    unique case (state_r)
      lcdws_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          mode_nxt = four_bit_cfg_r;
          step_nxt = lcdws_pkg::STEP_RS;
          byte_nxt = 2'd0;
          done_nxt = 1'b0;
        end
      end
      lcdws_pkg::ST_EMIT: begin
        emit = sts.out_free;
        if (sts.out_free) begin
          hold_cnt_nxt = hold_cfg_r;
          done_nxt     = step_end && byte_end;
          step_nxt     = step_end ? lcdws_pkg::STEP_RS : step_r + 3'd1;
          byte_nxt     = step_end ? byte_r + 2'd1 : byte_r;
        end
      end
      lcdws_pkg::ST_HOLD: begin
        if (!hold_over) hold_cnt_nxt = hold_cnt_r - 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lcdws_pkg::ST_IDLE;
      mode_r     <= 1'b1;
      step_r     <= lcdws_pkg::STEP_RS;
      byte_r     <= 2'd0;
      hold_cnt_r <= 16'd0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      step_r     <= step_nxt;
      byte_r     <= byte_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      done_r     <= done_nxt;
    end
  end

  // command to datapath
  always_comb begin
    cmd.load_req = accept;
    cmd.emit     = emit;
    cmd.four_bit = mode_r;
    cmd.step     = step_r;
    cmd.byte_idx = byte_r;
    cmd.last     = step_end && byte_end;
  end

endmodule

[rtl/lcdws_datapath.sv]
// datapath: request register, byte selection, pin levels and result register
// depends on lcdws_pkg
module lcdws_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdws_pkg::in_item_t    in_item,
  input  lcdws_pkg::ctrl_cmd_t   cmd,
  output lcdws_pkg::dp_status_t  sts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcdws_pkg::out_item_t   out_item
);

  lcdws_pkg::in_item_t  req_r;
  lcdws_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 rs_r, rs_nxt;
  logic                 en_r, en_nxt;
  logic [7:0]           bus_r, bus_nxt;
  logic [7:0]           cur_byte;
  logic                 cur_rs;
  logic                 out_take;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_item;
  end

  // byte for the current position of the request
  always_comb begin
    cur_rs = 1'b0;
    unique case (req_r.req_type)
      lcdws_pkg::REQ_CMD:  cur_byte = req_r.byte_value;
      lcdws_pkg::REQ_DATA: begin
        cur_byte = req_r.byte_value;
        cur_rs   = 1'b1;
      end
      lcdws_pkg::REQ_GOTO:
        cur_byte = lcdws_pkg::CMD_SET_DDRAM |
                   (lcdws_pkg::row_base(req_r.row) + {4'd0, req_r.column});
      default: cur_byte = lcdws_pkg::init_cmd(cmd.four_bit, cmd.byte_idx);
    endcase
  end

  // pin level changes for one step
  always_comb begin
    rs_nxt  = rs_r;
    en_nxt  = en_r;
    bus_nxt = bus_r;
    if (cmd.emit) begin
      unique case (cmd.step)
        lcdws_pkg::STEP_RS:     rs_nxt = cur_rs;
        lcdws_pkg::STEP_E_HI:   en_nxt = 1'b1;
        lcdws_pkg::STEP_HI_NIB: bus_nxt = cmd.four_bit ? (cur_byte & lcdws_pkg::NIB_HI_MASK)
                                                       : cur_byte;
        lcdws_pkg::STEP_E_LO:   en_nxt = 1'b0;
        lcdws_pkg::STEP_E_HI2:  en_nxt = 1'b1;
        lcdws_pkg::STEP_LO_NIB: bus_nxt = (cur_byte & lcdws_pkg::NIB_LO_MASK) << 4;
        lcdws_pkg::STEP_E_LO2:  en_nxt = 1'b0;
        default:                en_nxt = en_r;
      endcase
    end
  end

  // result register
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_take;
    out_item_nxt  = out_item_r;
    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.rs_pin     = rs_nxt;
      out_item_nxt.enable_pin = en_nxt;
      out_item_nxt.bus_value  = bus_nxt;
      out_item_nxt.last_step  = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      bus_r       <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rs_r        <= rs_nxt;
      en_r        <= en_nxt;
      bus_r       <= bus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.req_type = req_r.req_type;

endmodule

[rtl/char_lcd_write_sequencer_core.sv]
// Character LCD write sequencer, top level.
// Takes one request on in_valid/in_stall/in_item: a command byte, a data byte,
// a row/column go-to, or the power-up init list. Each request becomes a run of
// pin steps (RS, E, D0..D7) on out_valid/out_stall/out_item; last_step marks
// the final step of the request. 4-bit mode sends a byte as high then low
// nibble on D4..D7 in 7 steps; 8-bit mode sends it in 4 steps. Init gives 28
// steps in 4-bit mode and 12 in 8-bit mode.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 bus mode,
// 1 hold ticks); write only while idle. Mode is sampled when a request is taken.
// Timing: once a request is taken, the controller enters its emit state and
// the first step goes through the result register onto out_valid. Steps are
// then spaced by the hold timer in the controller, loaded with hold_ticks
// after each step; a step starts later only when the receiver still stalls
// the previous one in the result register once that hold is over. in_stall
// stays high to the end of the last hold; one request is worked on at a time.
// A stalled step holds in the result register and the sequencer waits on it.
// Reset (rst_n low, synchronous) clears the pin level registers to zero,
// selects 4-bit mode and 1000 hold ticks, and empties the result register.
// depends on lcdws_pkg, lcdws_ctrl and lcdws_datapath
module char_lcd_write_sequencer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lcdws_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lcdws_pkg::out_item_t  out_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata
);

  lcdws_pkg::ctrl_cmd_t  cmd;
  lcdws_pkg::dp_status_t sts;

  // step sequencing
  lcdws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // pin levels and result register
  lcdws_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/lcdws_checker.sv]
// port-level checks for the character lcd write sequencer, with bind to the top level
// depends on lcdws_pkg and char_lcd_write_sequencer_core
module lcdws_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input lcdws_pkg::out_item_t  out_item
);

  // a stalled step holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled step changed");

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // every request ends with the enable strobe low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_step |-> !out_item.enable_pin)
    else $error("last step leaves enable high");

  // reset empties the result register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind char_lcd_write_sequencer_core lcdws_checker u_lcdws_checker (.*);
